[design/llt_pkg.sv]
// llt_pkg: shared types, constants and the level word table for the
// log level tag counter. No dependencies.
`default_nettype none
package llt_pkg;

    localparam int C_COUNT_WIDTH = 32;
    localparam int C_NUM_LEVELS  = 8;
    localparam int C_QUEUE_DEPTH = 4;

    localparam logic [2:0] C_LEVEL_UNKNOWN = 3'd5;
    localparam logic [7:0] C_BAR           = 8'h7C;

    typedef struct packed {
        logic       op;
        logic [7:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  level;
        logic [31:0] level_count;
    } t_out_item;

    // words left-justified, padded with spaces
    localparam logic [63:0] C_WORD [C_NUM_LEVELS] = '{
        "CRITICAL", "WARNING ", "INFO    ", "DEBUG   ",
        "ERROR   ", "UNKNOWN ", "TRACE   ", "FATAL   "
    };
    localparam logic [3:0] C_LEN [C_NUM_LEVELS] = '{
        4'd8, 4'd7, 4'd4, 4'd5, 4'd5, 4'd7, 4'd5, 4'd5
    };

    function automatic logic [7:0] word_char(input logic [2:0] m, input logic [2:0] k);
        logic [63:0] w;
        w = C_WORD[m];
        return w[8*(7 - int'(k)) +: 8];
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if ((c >= 8'h61) && (c <= 8'h7A)) begin
            return c - 8'd32;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[design/llt_front.sv]
// llt_front: eight tag matchers stepped in parallel per byte; at end of
// line picks the level and pushes it to the queue. Uses llt_pkg.
`default_nettype none
module llt_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire llt_pkg::t_in_item i_item,
    output logic                   o_push,
    output logic [2:0]             o_push_level
);
    import llt_pkg::*;

    logic [3:0]              r_prog [C_NUM_LEVELS];
    logic [3:0]              n_prog [C_NUM_LEVELS];
    logic [C_NUM_LEVELS-1:0] r_matched;
    logic [C_NUM_LEVELS-1:0] n_matched;
    logic [2:0]              w_level;

    always_comb begin
        w_level = C_LEVEL_UNKNOWN;
        for (int i = C_NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_matched[i]) begin
                w_level = 3'(i);
            end
        end
    end

    for (genvar m = 0; m < C_NUM_LEVELS; m++) begin : g_match
        logic [3:0] w_done;
        logic [3:0] w_pm1;
        logic [7:0] w_want;
        logic [7:0] w_c;

        assign w_done = C_LEN[m] + 4'd1;
        assign w_pm1  = r_prog[m] - 4'd1;
        assign w_want = word_char(3'(m), w_pm1[2:0]);
        assign w_c    = i_item.char_in;

        always_comb begin
            n_prog[m] = r_prog[m];
            n_matched[m] = r_matched[m];
            if (i_accept) begin
                if (i_item.op) begin
                    n_prog[m] = 4'd0;
                    n_matched[m] = 1'b0;
                end else if (w_c == C_BAR) begin
                    if (r_prog[m] == w_done) begin
                        n_matched[m] = 1'b1;
                    end
                    n_prog[m] = 4'd1;
                end else if (r_prog[m] == 4'd0) begin
                    n_prog[m] = 4'd0;
                end else if (((r_prog[m] == 4'd1) || (r_prog[m] == w_done)) && is_ws(w_c)) begin
                    n_prog[m] = r_prog[m];
                end else if ((r_prog[m] < w_done) && (fold_upper(w_c) == w_want)) begin
                    n_prog[m] = r_prog[m] + 4'd1;
                end else begin
                    n_prog[m] = 4'd0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_prog[m] <= 4'd0;
            end else begin
                r_prog[m] <= n_prog[m];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= '0;
        end else begin
            r_matched <= n_matched;
        end
    end

    assign o_push       = i_accept && i_item.op;
    assign o_push_level = w_level;

endmodule
`default_nettype wire

[design/llt_queue.sv]
// llt_queue: short level queue between the matchers and the counters.
// Uses llt_pkg for its depth.
`default_nettype none
module llt_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [2:0] i_level,
    input  wire logic       i_pop,
    output logic [2:0]      o_level,
    output logic            o_empty,
    output logic            o_full
);
    import llt_pkg::*;

    localparam int PTR_W = $clog2(C_QUEUE_DEPTH);

    logic [2:0]       r_mem [C_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PTR_W+1)'(C_QUEUE_DEPTH));
    assign o_level = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[design/llt_back.sv]
// llt_back: per-level saturating counters and the output register.
// Uses llt_pkg.
`default_nettype none
module llt_back #(
    parameter int COUNT_WIDTH = llt_pkg::C_COUNT_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  wire logic [2:0]  i_level,
    output logic             o_pop,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output llt_pkg::t_out_item o_out_item
);
    import llt_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    logic [COUNT_WIDTH-1:0] r_cnt [C_NUM_LEVELS];
    logic [COUNT_WIDTH-1:0] w_cur;
    logic [COUNT_WIDTH-1:0] w_next;
    logic [EXT_W-1:0]       w_ext;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    assign o_pop  = !i_empty && (!r_out_valid || !i_out_stall);
    assign w_cur  = r_cnt[i_level];
    assign w_next = (&w_cur) ? w_cur : w_cur + 1'b1;
    assign w_ext  = EXT_W'(w_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < C_NUM_LEVELS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_cnt[i_level] <= w_next;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item.level       <= i_level;
            r_out_item.level_count <= w_ext[31:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

[design/log_level_tag_counter.sv]
// log_level_tag_counter: counts log lines by their bar-delimited level tag.
// One item (byte or end-of-line marker) accepted per cycle while the queue
// has room, a rate set by the matcher bank and counter update; a marker's
// level is queued, then popped into the output register once that is free.
// Synchronous reset clears matchers, queue and counters.
// Depends on llt_pkg, llt_front, llt_queue and llt_back.
`default_nettype none
module log_level_tag_counter #(
    parameter int COUNT_WIDTH = llt_pkg::C_COUNT_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire llt_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output llt_pkg::t_out_item      o_out_item
);
    import llt_pkg::*;

    logic       w_accept;
    logic       w_push;
    logic [2:0] w_push_level;
    logic       w_pop;
    logic [2:0] w_head;
    logic       w_empty;
    logic       w_full;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    llt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_item       (i_in_item),
        .o_push       (w_push),
        .o_push_level (w_push_level)
    );

    llt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_level (w_push_level),
        .i_pop   (w_pop),
        .o_level (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    llt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_level     (w_head),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

[tb/log_level_tag_counter_tb.sv]
// Self-checking bench for log_level_tag_counter: a short directed table of log lines, random
// tagged lines and noise, back-pressure and a stall-free stretch, checked by predictor or typed row.
// Depends on llt_pkg and the log_level_tag_counter RTL.
module log_level_tag_counter_tb;
    import llt_pkg::*;

    localparam int CNT_W      = C_COUNT_WIDTH;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 20;
    localparam int HOLD_LEN   = 200;
    localparam int RAND_ITEMS = 260;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [2:0] LVL_CRITICAL = 3'd0;
    localparam logic [2:0] LVL_WARNING  = 3'd1;
    localparam logic [2:0] LVL_INFO     = 3'd2;
    localparam logic [2:0] LVL_DEBUG    = 3'd3;
    localparam logic [2:0] LVL_ERROR    = 3'd4;
    localparam logic [2:0] LVL_UNKNOWN  = 3'd5;
    localparam logic [2:0] LVL_TRACE    = 3'd6;
    localparam logic [2:0] LVL_FATAL    = 3'd7;

    typedef struct {
        string       text;
        int          tail;
        bit          typed;
        logic [2:0]  lvl;
        logic [31:0] cnt;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    log_level_tag_counter #(
        .COUNT_WIDTH (CNT_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    string       level_word [8] = '{"CRITICAL", "WARNING", "INFO", "DEBUG",
                                    "ERROR", "UNKNOWN", "TRACE", "FATAL"};
    int unsigned word_pos [8];
    logic [7:0]  tag_hits;
    logic [63:0] level_tally [8];
    t_out_item   lines_due [$];
    t_row        dir_tab [4];
    int          errors;
    int          cycle_count;
    int          items_sent;
    int          hold_left;
    bit          idle_on;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    function automatic bit blank_byte(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do c = 8'($urandom); while (c == C_BAR);
        return c;
    endfunction

    function automatic logic [7:0] blank_pick();
        int unsigned r;
        r = $urandom_range(5);
        return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
    endfunction

    task automatic scan_byte(input logic [7:0] c);
        int unsigned done;
        for (int m = 0; m < 8; m++) begin
            done = level_word[m].len() + 1;
            if (c == C_BAR) begin
                if (word_pos[m] == done) begin
                    tag_hits[m] = 1'b1;
                end
                word_pos[m] = 1;
            end else if (word_pos[m] != 0 &&
                         !((word_pos[m] == 1 || word_pos[m] == done) && blank_byte(c))) begin
                if (word_pos[m] < done && upcase(c) == level_word[m][word_pos[m] - 1]) begin
                    word_pos[m]++;
                end else begin
                    word_pos[m] = 0;
                end
            end
        end
    endtask

    task automatic close_line(output t_out_item r);
        logic [2:0] lvl;
        lvl = LVL_UNKNOWN;
        for (int m = 7; m >= 0; m--) begin
            if (tag_hits[m]) begin
                lvl = 3'(m);
            end
        end
        if (level_tally[lvl] < (64'd1 << CNT_W) - 64'd1) begin
            level_tally[lvl]++;
        end
        r.level       = lvl;
        r.level_count = level_tally[lvl][31:0];
        foreach (word_pos[m]) word_pos[m] = 0;
        tag_hits = '0;
    endtask

    // entered and left at a falling edge; valid stays high between back-to-back items
    task automatic drive_item(input logic op, input logic [7:0] c);
        t_out_item r;
        if (idle_on) begin
            while ($urandom_range(99) < 35) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid = 1'b1;
        i_in_item  = '{op: op, char_in: c};
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (op == OP_BYTE) begin
            scan_byte(c);
        end else begin
            close_line(r);
            lines_due.push_back(r);
        end
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) drive_item(OP_BYTE, s[i]);
    endtask

    task automatic end_line();
        drive_item(OP_EOL, 8'($urandom));
    endtask

    task automatic random_line();
        string      w;
        logic [7:0] c;
        if ($urandom_range(99) < 70) begin
            repeat ($urandom_range(2)) drive_item(OP_BYTE, plain_byte());
            repeat (($urandom_range(9) == 0) ? 2 : 1) begin
                w = level_word[$urandom_range(7)];
                drive_item(OP_BYTE, C_BAR);
                repeat ($urandom_range(2)) drive_item(OP_BYTE, blank_pick());
                for (int i = 0; i < w.len(); i++) begin
                    c = w[i];
                    if ($urandom_range(1)) c = c + 8'd32;
                    if ($urandom_range(99) < 3) c = 8'($urandom);
                    drive_item(OP_BYTE, c);
                end
                repeat ($urandom_range(2)) drive_item(OP_BYTE, blank_pick());
                if ($urandom_range(9) != 0) drive_item(OP_BYTE, C_BAR);
            end
            repeat ($urandom_range(2)) drive_item(OP_BYTE, plain_byte());
        end else begin
            repeat ($urandom_range(8)) begin
                drive_item(OP_BYTE, ($urandom_range(4) == 0) ? C_BAR : 8'($urandom));
            end
        end
        end_line();
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (lines_due.size() != 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_out
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (lines_due.size() == 0) begin
                report($sformatf("unexpected item level %0d count %0d",
                                 o_out_item.level, o_out_item.level_count));
            end else begin
                want = lines_due.pop_front();
                if (o_out_item.level != want.level) begin
                    report($sformatf("level %0d, want %0d", o_out_item.level, want.level));
                end
                if (o_out_item.level_count != want.level_count) begin
                    report($sformatf("count %0d, want %0d",
                                     o_out_item.level_count, want.level_count));
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = idle_on && ($urandom_range(99) < 35);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("log_level_tag_counter verification failed");
        $finish;
    end

    initial begin
        int target;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        idle_on    = 1'b1;
        hold_left  = 0;
        errors     = 0;
        items_sent = 0;
        tag_hits   = '0;
        foreach (word_pos[m]) word_pos[m] = 0;
        foreach (level_tally[m]) level_tally[m] = '0;

        // empty line, bar restart with case folding, broken word with top byte, two tags
        dir_tab[0] = '{"", -1, 1'b1, LVL_UNKNOWN, 32'd1};
        dir_tab[1] = '{"||iNfO\t|", 0, 1'b1, LVL_INFO, 32'd1};
        dir_tab[2] = '{"|fat", 255, 1'b1, LVL_UNKNOWN, 32'd2};
        dir_tab[3] = '{"|\013debug |info|", -1, 1'b0, LVL_UNKNOWN, 32'd0};

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[r]) begin
            send_text(dir_tab[r].text);
            if (dir_tab[r].tail >= 0) drive_item(OP_BYTE, 8'(dir_tab[r].tail));
            end_line();
            if (dir_tab[r].typed) begin
                lines_due[lines_due.size() - 1] = '{level: dir_tab[r].lvl,
                                                     level_count: dir_tab[r].cnt};
            end
        end

        target = items_sent + RAND_ITEMS / 2;
        while (items_sent < target) random_line();

        // receiver holds off while empty lines keep coming, so the block fills up
        hold_left = HOLD_LEN;
        repeat (12) end_line();
        wait_drained();
        @(negedge i_clk);

        target = items_sent + RAND_ITEMS / 2;
        while (items_sent < target) random_line();

        // no idling on either side for a stretch
        idle_on = 1'b0;
        repeat (8) random_line();
        idle_on = 1'b1;
        repeat (5) random_line();

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (errors == 0) begin
            $display("log_level_tag_counter verification clean");
        end else begin
            $display("log_level_tag_counter verification failed");
        end
        $finish;
    end

endmodule

[log_level_tag_counter.f]
design/llt_pkg.sv
design/llt_front.sv
design/llt_queue.sv
design/llt_back.sv
design/log_level_tag_counter.sv
tb/log_level_tag_counter_tb.sv
